// ===== hw/rtl/eif_pkg.sv =====
// Shared types, constants and saturation helper for the inviscid flux pipeline.
`default_nettype none

package eif_pkg;

   // Number of result items produced for one point.
   localparam int NUM_EQUATIONS = 5;

   // Restoring divider: one quotient bit per stage, 64-bit dividend, 32-bit divisor.
   localparam int DIV_STAGES = 64;
   localparam int DVS_W      = 32;

   // Ratio of specific heats after reset (1.4 in Q16.16) and one in Q16.16.
   localparam logic [17:0] GAMMA_RESET = 18'd91750;
   localparam logic [18:0] ONE_Q16     = 19'd65536;

   // Equation codes carried on the result channel.
   typedef logic [2:0] eq_type;
   localparam eq_type EQ_MASS   = 3'd0;
   localparam eq_type EQ_MOM_X  = 3'd1;
   localparam eq_type EQ_MOM_Y  = 3'd2;
   localparam eq_type EQ_MOM_Z  = 3'd3;
   localparam eq_type EQ_ENERGY = 3'(NUM_EQUATIONS - 1);

   // Item data that rides alongside the dividers.
   typedef struct packed {
      logic             fault;
      logic [31:0]      e;
      logic [2:0][31:0] m;
   } eif_side_type;

   // Everything the result sequencer needs for one point.
   typedef struct packed {
      logic             fault;
      logic [31:0]      h;
      logic [31:0]      p;
      logic [2:0][31:0] m;
      logic [2:0][31:0] u;
   } eif_point_type;

   // Clamp a wide signed value to the signed 32-bit range.
   function automatic logic [31:0] sat32(input logic signed [67:0] x);
      if (x > 68'sh0_7FFF_FFFF) begin
         return 32'h7FFF_FFFF;
      end
      if (x < -68'sh0_8000_0000) begin
         return 32'h8000_0000;
      end
      return x[31:0];
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/eif_div.sv =====
// Pipelined unsigned restoring divider, one quotient bit per register stage.
`default_nettype none

module eif_div
   import eif_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic [DIV_STAGES-1:0] dividend,
   input  wire logic [DVS_W-1:0]      divisor,
   output logic      [DIV_STAGES-1:0] quotient
);

   logic [DVS_W-1:0]      rem_ff  [DIV_STAGES];
   logic [DIV_STAGES-1:0] wrd_ff  [DIV_STAGES];
   logic [DVS_W-1:0]      dvs_ff  [DIV_STAGES];
   logic [DVS_W-1:0]      rem_src [DIV_STAGES];
   logic [DIV_STAGES-1:0] wrd_src [DIV_STAGES];
   logic [DVS_W-1:0]      dvs_src [DIV_STAGES];
   logic [DVS_W-1:0]      rem_in  [DIV_STAGES];
   logic [DIV_STAGES-1:0] wrd_in  [DIV_STAGES];

   // Each stage shifts one dividend bit into the remainder and tries a subtract.
   // The word register shifts dividend bits out and quotient bits in.
   for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
      logic [DVS_W+1:0] trial;

      if (i == 0) begin : g_first
         assign rem_src[i] = '0;
         assign wrd_src[i] = dividend;
         assign dvs_src[i] = divisor;
      end else begin : g_next
         assign rem_src[i] = rem_ff[i-1];
         assign wrd_src[i] = wrd_ff[i-1];
         assign dvs_src[i] = dvs_ff[i-1];
      end

      assign trial = {1'b0, rem_src[i], wrd_src[i][DIV_STAGES-1]} - {2'b00, dvs_src[i]};
      assign rem_in[i] = trial[DVS_W+1] ?
                         {rem_src[i][DVS_W-2:0], wrd_src[i][DIV_STAGES-1]} :
                         trial[DVS_W-1:0];
      assign wrd_in[i] = {wrd_src[i][DIV_STAGES-2:0], ~trial[DVS_W+1]};
   end

   // Stage registers carry data only; the valid bits travel in the caller.
   always_ff @(posedge clock) begin
      for (int i = 0; i < DIV_STAGES; i++) begin
         rem_ff[i] <= rem_in[i];
         wrd_ff[i] <= wrd_in[i];
         dvs_ff[i] <= dvs_src[i];
      end
   end

   assign quotient = wrd_ff[DIV_STAGES-1];

endmodule

`default_nettype wire

// ===== hw/rtl/eif_emit.sv =====
// Result sequencer: turns one point into five flux items, mass first and energy last.
`default_nettype none

module eif_emit
   import eif_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          pt_vld,
   input  wire eif_point_type pt,
   output logic               rsp_strobe,
   output logic [2:0]         rsp_equation,
   output logic [31:0]        rsp_flux_x,
   output logic [31:0]        rsp_flux_y,
   output logic [31:0]        rsp_flux_z,
   output logic               rsp_last,
   output logic               rsp_fault
);

   eif_point_type      hold_ff;
   logic               act_ff;
   eq_type             cnt_ff;
   logic               act_in;
   eq_type             cnt_in;

   logic signed [31:0] mul_a;
   logic signed [63:0] prod_in [3];

   logic               x_vld_ff;
   eq_type             x_eq_ff;
   logic signed [63:0] x_prod_ff [3];
   logic [31:0]        x_p_ff;
   logic [31:0]        x_m_ff [3];
   logic               x_fault_ff;

   logic [31:0]        flux_in [3];
   logic [1:0]         diag_idx;
   logic signed [67:0] sum_v;

   logic               rsp_strobe_ff;
   eq_type             rsp_eq_ff;
   logic [31:0]        rsp_flux_ff [3];
   logic               rsp_fault_ff;

   // Equation counter: a new point restarts it, otherwise it runs to energy.
   always_comb begin
      act_in = act_ff;
      cnt_in = cnt_ff;
      if (pt_vld) begin
         act_in = 1'b1;
         cnt_in = EQ_MASS;
      end else if (act_ff) begin
         if (cnt_ff == EQ_ENERGY) begin
            act_in = 1'b0;
         end else begin
            cnt_in = cnt_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff   <= 1'b0;
         cnt_ff   <= EQ_MASS;
         x_vld_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         act_ff   <= act_in;
         cnt_ff   <= cnt_in;
         x_vld_ff <= act_ff;
         rsp_strobe_ff <= x_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pt_vld) begin
         hold_ff <= pt;
      end
   end

   // Multiply stage: the left factor is a momentum or the enthalpy term.
   always_comb begin
      case (cnt_ff)
         EQ_MOM_X: mul_a = $signed(hold_ff.m[0]);
         EQ_MOM_Y: mul_a = $signed(hold_ff.m[1]);
         EQ_MOM_Z: mul_a = $signed(hold_ff.m[2]);
         default:  mul_a = $signed(hold_ff.h);
      endcase
      for (int j = 0; j < 3; j++) begin
         prod_in[j] = mul_a * $signed(hold_ff.u[j]);
      end
   end

   always_ff @(posedge clock) begin
      x_eq_ff    <= cnt_ff;
      x_p_ff     <= hold_ff.p;
      x_fault_ff <= hold_ff.fault;
      for (int j = 0; j < 3; j++) begin
         x_prod_ff[j] <= prod_in[j];
         x_m_ff[j]    <= hold_ff.m[j];
      end
   end

   // Scale, add pressure on the diagonal, saturate; mass passes the momenta through and a fault forces zero.
   assign diag_idx = 2'(x_eq_ff - EQ_MOM_X);

   always_comb begin
      sum_v = '0;
      for (int j = 0; j < 3; j++) begin
         sum_v = 68'(x_prod_ff[j] >>> 16);
         if (x_eq_ff != EQ_ENERGY && diag_idx == 2'(j)) begin
            sum_v = sum_v + 68'($signed(x_p_ff));
         end
         if (x_fault_ff) begin
            flux_in[j] = '0;
         end else if (x_eq_ff == EQ_MASS) begin
            flux_in[j] = x_m_ff[j];
         end else begin
            flux_in[j] = sat32(sum_v);
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_eq_ff    <= x_eq_ff;
      rsp_fault_ff <= x_fault_ff;
      for (int j = 0; j < 3; j++) begin
         rsp_flux_ff[j] <= flux_in[j];
      end
   end

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_equation = rsp_eq_ff;
   assign rsp_flux_x   = rsp_flux_ff[0];
   assign rsp_flux_y   = rsp_flux_ff[1];
   assign rsp_flux_z   = rsp_flux_ff[2];
   assign rsp_last     = (rsp_eq_ff == EQ_ENERGY);
   assign rsp_fault    = rsp_fault_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/euler_inviscid_flux_3d.sv =====
// Inviscid flux of the 3-D Euler equations for an ideal gas, Q16.16 pipeline.
// The first result, mass, reaches the ports after the divider pipeline, and
// the other four follow on consecutive cycles, energy last.
// A new item is taken only while busy is low, a limit set by the single result
// channel; busy rises after each accept. The receiver cannot stall.
// Reset clears all valid bits and the busy counter and sets gamma to 1.4.
`default_nettype none

module euler_inviscid_flux_3d
   import eif_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [31:0] req_density,
   input  wire logic [31:0] req_momentum_x,
   input  wire logic [31:0] req_momentum_y,
   input  wire logic [31:0] req_momentum_z,
   input  wire logic [31:0] req_total_energy,
   output logic             rsp_strobe,
   output logic [2:0]       rsp_equation,
   output logic [31:0]      rsp_flux_x,
   output logic [31:0]      rsp_flux_y,
   output logic [31:0]      rsp_flux_z,
   output logic             rsp_last,
   output logic             rsp_fault,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [17:0] csr_data
);

   localparam int RSP_DELAY = DIV_STAGES + 9;

   logic        acc;
   logic [2:0]  gap_ff;
   logic [17:0] gamma_ff;

   logic               a_vld_ff;
   logic [31:0]        a_rho_ff;
   logic [31:0]        a_m_ff [3];
   logic [31:0]        a_e_ff;
   logic [31:0]        abs_m [3];
   logic signed [63:0] sq [3];

   logic               b_vld_ff;
   logic [62:0]        b_sq_ff [3];
   logic [47:0]        b_vdd_ff [3];
   logic [30:0]        b_rho_ff;
   eif_side_type       b_side_ff;

   logic               c_vld_ff;
   logic [63:0]        c_sum_ff;
   logic [47:0]        c_vdd_ff [3];
   logic [30:0]        c_rho_ff;
   eif_side_type       c_side_ff;

   logic               side_vld_ff [DIV_STAGES];
   eif_side_type       side_ff [DIV_STAGES];
   logic [63:0]        vel_q [3];
   logic [63:0]        ke_q;
   eif_side_type       dsd;

   logic [31:0]        u_in [3];
   logic [64:0]        inner;
   logic [48:0]        inner_in;

   logic               d_vld_ff;
   logic signed [48:0] d_inner_ff;
   logic [31:0]        d_u_ff [3];
   eif_side_type       d_side_ff;

   logic signed [18:0] g1;
   logic               f_vld_ff;
   logic signed [67:0] f_prod_ff;
   logic [31:0]        f_u_ff [3];
   eif_side_type       f_side_ff;

   logic [31:0]        p_in;
   logic [31:0]        h_in;
   logic               pt_vld_ff;
   eif_point_type      pt_ff;

   // Input handshake: an item is accepted when start is high and busy is low.
   assign acc  = start & ~busy;
   assign busy = (gap_ff != 3'd0);
   assign csr_ready = 1'b1;

   // Control registers: busy counter, gamma, and stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff    <= 3'd0;
         gamma_ff  <= GAMMA_RESET;
         a_vld_ff  <= 1'b0;
         b_vld_ff  <= 1'b0;
         c_vld_ff  <= 1'b0;
         d_vld_ff  <= 1'b0;
         f_vld_ff  <= 1'b0;
         pt_vld_ff <= 1'b0;
         for (int i = 0; i < DIV_STAGES; i++) begin
            side_vld_ff[i] <= 1'b0;
         end
      end else begin
         if (acc) begin
            gap_ff <= 3'(NUM_EQUATIONS - 1);
         end else if (gap_ff != 3'd0) begin
            gap_ff <= gap_ff - 3'd1;
         end
         if (csr_valid && csr_ready) begin
            gamma_ff <= csr_data;
         end
         a_vld_ff <= acc;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
         side_vld_ff[0] <= c_vld_ff;
         for (int i = 1; i < DIV_STAGES; i++) begin
            side_vld_ff[i] <= side_vld_ff[i-1];
         end
         d_vld_ff  <= side_vld_ff[DIV_STAGES-1];
         f_vld_ff  <= d_vld_ff;
         pt_vld_ff <= f_vld_ff;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (acc) begin
         a_rho_ff  <= req_density;
         a_m_ff[0] <= req_momentum_x;
         a_m_ff[1] <= req_momentum_y;
         a_m_ff[2] <= req_momentum_z;
         a_e_ff    <= req_total_energy;
      end
   end

   // Squares of the momenta and magnitudes for the velocity dividends.
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         abs_m[j] = a_m_ff[j][31] ? 32'(-$signed(a_m_ff[j])) : a_m_ff[j];
         sq[j]    = $signed(a_m_ff[j]) * $signed(a_m_ff[j]);
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < 3; j++) begin
         b_sq_ff[j]   <= sq[j][62:0];
         b_vdd_ff[j]  <= {abs_m[j], 16'h0000};
         b_side_ff.m[j] <= a_m_ff[j];
      end
      b_rho_ff        <= a_rho_ff[30:0];
      b_side_ff.e     <= a_e_ff;
      b_side_ff.fault <= a_rho_ff[31] || (a_rho_ff == 32'd0);
   end

   // Sum of squares; the dividers take their operands from here.
   always_ff @(posedge clock) begin
      c_sum_ff  <= 64'(b_sq_ff[0]) + 64'(b_sq_ff[1]) + 64'(b_sq_ff[2]);
      c_vdd_ff  <= b_vdd_ff;
      c_rho_ff  <= b_rho_ff;
      c_side_ff <= b_side_ff;
   end

   for (genvar j = 0; j < 3; j++) begin : g_vel
      eif_div u_div (
         .clock    (clock),
         .dividend ({16'h0000, c_vdd_ff[j]}),
         .divisor  ({1'b0, c_rho_ff}),
         .quotient (vel_q[j])
      );
   end

   eif_div u_ke_div (
      .clock    (clock),
      .dividend (c_sum_ff),
      .divisor  ({c_rho_ff, 1'b0}),
      .quotient (ke_q)
   );

   // Item data delayed alongside the dividers.
   always_ff @(posedge clock) begin
      side_ff[0] <= c_side_ff;
      for (int i = 1; i < DIV_STAGES; i++) begin
         side_ff[i] <= side_ff[i-1];
      end
   end

   assign dsd = side_ff[DIV_STAGES-1];

   // Signed, saturated velocities and E - ke clamped to 49 bits; any clamped
   // magnitude still drives the pressure product into saturation unless gamma is one.
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         if (dsd.m[j][31]) begin
            u_in[j] = (vel_q[j] > 64'h8000_0000) ? 32'h8000_0000 : 32'(-vel_q[j][31:0]);
         end else begin
            u_in[j] = (vel_q[j] > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : vel_q[j][31:0];
         end
      end
      inner = {{33{dsd.e[31]}}, dsd.e} - {1'b0, ke_q};
      if (inner[64:48] == {17{inner[64]}}) begin
         inner_in = inner[48:0];
      end else if (inner[64]) begin
         inner_in = {1'b1, 48'h0};
      end else begin
         inner_in = {1'b0, {48{1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      d_inner_ff <= $signed(inner_in);
      d_u_ff     <= u_in;
      d_side_ff  <= dsd;
   end

   // Pressure product (gamma - 1) * (E - ke).
   assign g1 = $signed({1'b0, gamma_ff} - ONE_Q16);

   always_ff @(posedge clock) begin
      f_prod_ff <= d_inner_ff * g1;
      f_u_ff    <= d_u_ff;
      f_side_ff <= d_side_ff;
   end

   // Pressure and enthalpy term, both saturated.
   assign p_in = sat32(f_prod_ff >>> 16);
   assign h_in = sat32(68'($signed(f_side_ff.e)) + 68'($signed(p_in)));

   always_ff @(posedge clock) begin
      pt_ff.fault <= f_side_ff.fault;
      pt_ff.h     <= h_in;
      pt_ff.p     <= p_in;
      pt_ff.m     <= f_side_ff.m;
      for (int j = 0; j < 3; j++) begin
         pt_ff.u[j] <= f_u_ff[j];
      end
   end

   eif_emit u_emit (
      .clock        (clock),
      .reset        (reset),
      .pt_vld       (pt_vld_ff),
      .pt           (pt_ff),
      .rsp_strobe   (rsp_strobe),
      .rsp_equation (rsp_equation),
      .rsp_flux_x   (rsp_flux_x),
      .rsp_flux_y   (rsp_flux_y),
      .rsp_flux_z   (rsp_flux_z),
      .rsp_last     (rsp_last),
      .rsp_fault    (rsp_fault)
   );

   // Every accepted item brings its mass result out after the pipeline delay RSP_DELAY.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      acc |-> ##RSP_DELAY (rsp_strobe && rsp_equation == EQ_MASS))
      else $error("mass result missing after pipeline delay");

   // Results of one item come on consecutive cycles in equation order.
   a_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |=>
      (rsp_strobe && rsp_equation == $past(rsp_equation) + 3'd1))
      else $error("result sequence broken");

   // The fault flag is the same on all results of one item.
   a_fault_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |=> (rsp_fault == $past(rsp_fault)))
      else $error("fault flag changed within an item");

   // A faulted item carries zero fluxes.
   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_fault) |->
      (rsp_flux_x == 32'd0 && rsp_flux_y == 32'd0 && rsp_flux_z == 32'd0))
      else $error("nonzero flux on faulted item");

endmodule

`default_nettype wire

// ===== tb/euler_inviscid_flux_3d_tb.sv =====
// Testbench for the 3-D Euler inviscid flux block: a scoreboard predicts and checks the results.
`timescale 1ns / 100ps

module euler_inviscid_flux_3d_tb
   import eif_pkg::*;
();

   // One result item as seen on the result ports.
   typedef struct {
      logic [2:0]  equation;
      logic [31:0] flux [3];
      logic        last;
      logic        fault;
   } flux_rec_type;

   // Predicts the five flux items of each accepted point and checks arriving ones.
   class flux_scoreboard_type;
      flux_rec_type pending [$];
      logic [17:0]  gamma;

      function new();
         gamma = GAMMA_RESET;
      endfunction

      static function longint clamp32(longint x);
         if (x > 64'sd2147483647) begin
            return 64'sd2147483647;
         end
         if (x < -64'sd2147483648) begin
            return -64'sd2147483648;
         end
         return x;
      endfunction

      // Saturated pressure from (gamma - 1) times the internal energy term.
      function longint pressure(longint inner);
         longint          g1;
         longint unsigned mi;
         longint unsigned mg;
         longint unsigned prod;
         longint          s;
         bit              neg;
         g1   = longint'(gamma) - 65536;
         neg  = (inner < 0) != (g1 < 0);
         mi   = (inner < 0) ? longint'(-inner) : inner;
         mg   = (g1 < 0) ? longint'(-g1) : g1;
         if (mi == 0 || mg == 0) begin
            return 0;
         end
         if (mi > (64'd1 << 47) / mg) begin
            return neg ? -64'sd2147483648 : 64'sd2147483647;
         end
         prod = mi * mg;
         s    = neg ? -longint'(prod) : longint'(prod);
         return clamp32(s >>> 16);
      endfunction

      // Note one accepted point and queue the five fluxes it must produce.
      function void note_point(logic [31:0] dens, logic [31:0] mom [3], logic [31:0] ener);
         longint          r;
         longint          e;
         longint          m [3];
         longint          u [3];
         longint          f [5][3];
         longint unsigned sumsq;
         longint          ke;
         longint          p;
         longint          h;
         longint          v;
         bit              flt;
         flux_rec_type    rec;
         r     = longint'(signed'(dens));
         e     = longint'(signed'(ener));
         flt   = (r <= 0);
         sumsq = 0;
         for (int j = 0; j < 3; j++) begin
            m[j] = longint'(signed'(mom[j]));
         end
         for (int k = 0; k < 5; k++) begin
            for (int j = 0; j < 3; j++) begin
               f[k][j] = 0;
            end
         end
         if (!flt) begin
            for (int j = 0; j < 3; j++) begin
               u[j]  = clamp32((m[j] * 65536) / r);
               sumsq += longint'(m[j] * m[j]);
            end
            ke = longint'(sumsq / longint'(r * 2));
            p  = pressure(e - ke);
            h  = clamp32(e + p);
            for (int j = 0; j < 3; j++) begin
               f[0][j] = m[j];
               f[4][j] = clamp32((h * u[j]) >>> 16);
            end
            for (int k = 0; k < 3; k++) begin
               for (int j = 0; j < 3; j++) begin
                  v = (m[k] * u[j]) >>> 16;
                  if (k == j) begin
                     v += p;
                  end
                  f[k + 1][j] = clamp32(v);
               end
            end
         end
         for (int k = 0; k < NUM_EQUATIONS; k++) begin
            rec.equation = 3'(k);
            for (int j = 0; j < 3; j++) begin
               rec.flux[j] = f[k][j][31:0];
            end
            rec.last  = (3'(k) == EQ_ENERGY);
            rec.fault = flt;
            pending.insert(pending.size(), rec);
         end
      endfunction

      // Compare a result with the oldest expectation; returns an empty string on a match.
      function string check_flux(flux_rec_type got);
         flux_rec_type want;
         string        msg;
         if (pending.size() == 0) begin
            return $sformatf("result eq %0d arrived with nothing expected", got.equation);
         end
         want = pending.pop_front();
         msg  = "";
         if (got.equation !== want.equation) begin
            msg = {msg, $sformatf(" equation %0d/%0d", got.equation, want.equation)};
         end
         for (int j = 0; j < 3; j++) begin
            if (got.flux[j] !== want.flux[j]) begin
               msg = {msg, $sformatf(" flux[%0d] %h/%h", j, got.flux[j], want.flux[j])};
            end
         end
         if (got.last !== want.last) begin
            msg = {msg, $sformatf(" last %b/%b", got.last, want.last)};
         end
         if (got.fault !== want.fault) begin
            msg = {msg, $sformatf(" fault %b/%b", got.fault, want.fault)};
         end
         if (msg != "") begin
            msg = {$sformatf("eq %0d got/want:", want.equation), msg};
         end
         return msg;
      endfunction
   endclass

   localparam int CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [31:0] req_density = '0;
   logic [31:0] req_momentum_x = '0;
   logic [31:0] req_momentum_y = '0;
   logic [31:0] req_momentum_z = '0;
   logic [31:0] req_total_energy = '0;
   logic        rsp_strobe;
   logic [2:0]  rsp_equation;
   logic [31:0] rsp_flux_x;
   logic [31:0] rsp_flux_y;
   logic [31:0] rsp_flux_z;
   logic        rsp_last;
   logic        rsp_fault;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [17:0] csr_data = '0;

   int                  mismatches = 0;
   int                  cycles = 0;
   flux_scoreboard_type board = new();

   euler_inviscid_flux_3d dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_density(req_density), .req_momentum_x(req_momentum_x),
      .req_momentum_y(req_momentum_y), .req_momentum_z(req_momentum_z),
      .req_total_energy(req_total_energy),
      .rsp_strobe(rsp_strobe), .rsp_equation(rsp_equation),
      .rsp_flux_x(rsp_flux_x), .rsp_flux_y(rsp_flux_y), .rsp_flux_z(rsp_flux_z),
      .rsp_last(rsp_last), .rsp_fault(rsp_fault),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   // Print one mismatch and count it.
   task automatic report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      mismatches++;
   endtask

   // Result monitor: every strobed cycle carries one item.
   always @(posedge clock) begin
      flux_rec_type got;
      string        msg;
      if (!reset && rsp_strobe) begin
         got.equation = rsp_equation;
         got.flux[0]  = rsp_flux_x;
         got.flux[1]  = rsp_flux_y;
         got.flux[2]  = rsp_flux_z;
         got.last     = rsp_last;
         got.fault    = rsp_fault;
         msg = board.check_flux(got);
         if (msg != "") begin
            report(msg);
         end
      end
   end

   // Watchdog on total run length.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Present one point and hold start until the block takes it.
   task automatic send_point(logic [31:0] d, logic [31:0] mx, logic [31:0] my,
                             logic [31:0] mz, logic [31:0] e);
      logic [31:0] mom [3];
      mom = '{mx, my, mz};
      start            <= 1'b1;
      req_density      <= d;
      req_momentum_x   <= mx;
      req_momentum_y   <= my;
      req_momentum_z   <= mz;
      req_total_energy <= e;
      do begin
         @(posedge clock);
      end while (!(start && !busy));
      board.note_point(d, mom, e);
   endtask

   // Random idle gap on the sender: mostly none or short, sometimes long.
   task automatic sender_gap();
      int n;
      n = $urandom_range(0, 99);
      if (n < 40) begin
         return;
      end
      n = (n < 90) ? $urandom_range(1, 4) : $urandom_range(10, 40);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Wait until every expected item is in, plus a short settle.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
   endtask

   // Write gamma through the configuration channel while the block is idle.
   task automatic write_gamma(logic [17:0] g);
      csr_valid <= 1'b1;
      csr_data  <= g;
      do begin
         @(posedge clock);
      end while (!(csr_valid && csr_ready));
      csr_valid    <= 1'b0;
      board.gamma  = g;
      @(posedge clock);
   endtask

   // Any 32-bit pattern, leaning on the edges.
   function automatic logic [31:0] raw32();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'($signed($urandom_range(0, 8)) - 4);
         default: return $urandom();
      endcase
   endfunction

   // One random point: mostly physical states, the rest noise or faulty density.
   task automatic random_point();
      logic [31:0] d;
      logic [31:0] m [3];
      logic [31:0] e;
      int          kind;
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
         d = $urandom_range(1, 32'h0010_0000 << $urandom_range(0, 8));
         for (int j = 0; j < 3; j++) begin
            m[j] = 32'($signed(32'($urandom_range(0, 32'h0080_0000)) >>> $urandom_range(0, 12))
                       * ($urandom_range(0, 1) ? -1 : 1));
         end
         e = $urandom_range(0, 32'h7FFF_FFFF) >> $urandom_range(0, 10);
      end else if (kind < 85) begin
         d = raw32();
         m = '{raw32(), raw32(), raw32()};
         e = raw32();
      end else begin
         d = -32'($urandom_range(0, 32'h7FFF_FFFF));
         m = '{raw32(), raw32(), raw32()};
         e = raw32();
      end
      send_point(d, m[0], m[1], m[2], e);
   endtask

   initial begin
      logic [17:0] gammas [6];
      gammas = '{18'd65537, 18'd196608, 18'd32768, 18'd0,
                 18'($urandom_range(65537, 196608)), GAMMA_RESET};

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed points at the reset gamma.
      send_point(32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 32'h0000_8000, 32'h0010_0000);
      send_point(32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
      send_point(32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      send_point(32'hFFFF_FFFF, 32'h1234_5678, 32'h0, 32'h0, 32'h0);
      send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      sender_gap();
      send_point(32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0);
      send_point(32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h8000_0000);
      send_point(32'h0000_0100, 32'h0100_0000, 32'h0, 32'h0, 32'h0000_0001);
      send_point(32'h0002_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0001, 32'h0400_0000);
      drain();

      // Random phases, one gamma setting each, extremes and below one included.
      foreach (gammas[g]) begin
         write_gamma(gammas[g]);
         for (int i = 0; i < 76; i++) begin
            random_point();
            if ($urandom_range(0, 39) == 0) begin
               drain();
            end else begin
               sender_gap();
            end
         end
         drain();
      end

      repeat (80) @(posedge clock);
      if (mismatches == 0 && board.pending.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
